// File: rtl/core/kla_pkg.sv
`timescale 1ns / 1ps

package kla_pkg;

	localparam int KEY_W     = 56;
	localparam int KEY_BYTES = 7;
	localparam int KEY_USED  = (KEY_BYTES > 7) ? 7 : KEY_BYTES;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_USED);

	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] RELOAD_RST = 4'd10;

	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_ALARM_RELOAD = 1'b0;

	typedef enum logic [1:0] {
		KIND_KEY    = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_CHARGE = 2'd2,
		KIND_UNLOCK = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OUT_NONE     = 3'd0,
		OUT_MISMATCH = 3'd1,
		OUT_UNLOCKED = 3'd2,
		OUT_NO_OBJ   = 3'd3,
		OUT_LOCKED   = 3'd4,
		OUT_IGNORED  = 3'd5,
		OUT_COUNT    = 3'd6,
		OUT_ALARM    = 3'd7
	} outcome_t;

	typedef enum logic [1:0] {
		BEEP_OFF  = 2'd0,
		BEEP_WARN = 2'd1,
		BEEP_OK   = 2'd2,
		BEEP_RSVD = 2'd3
	} beep_t;

	typedef struct packed {
		logic             locked;
		logic             waiting;
		logic             charging;
		logic             alarm;
		logic [KEY_W-1:0] stored_key;
		logic [CNT_W-1:0] count;
		logic             object_seen;
	} state_t;

	typedef struct packed {
		outcome_t         outcome;
		beep_t            beep;
		logic             publish;
		logic [KEY_W-1:0] key_out;
	} result_t;

endpackage

// File: rtl/core/kla_cfg.sv
`timescale 1ns / 1ps

module kla_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kla_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [kla_pkg::CNT_W-1:0]    alarm_reload
);

	logic [kla_pkg::CNT_W-1:0] reload_q;
	logic                      sel_reload;

	assign sel_reload = (paddr[kla_pkg::ADDR_W-1] == kla_pkg::REG_ALARM_RELOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= kla_pkg::RELOAD_RST;
		end else if (psel && penable && pwrite && pready && sel_reload) begin
			reload_q <= pwdata[kla_pkg::CNT_W-1:0];
		end
	end

	assign pready       = 1'b1;
	assign prdata       = sel_reload ? {{(32 - kla_pkg::CNT_W){1'b0}}, reload_q} : 32'd0;
	assign alarm_reload = reload_q;

endmodule

// File: rtl/core/kla_step.sv
`timescale 1ns / 1ps

module kla_step (
	input  kla_pkg::state_t                cur,
	input  logic [1:0]                     kind,
	input  logic [kla_pkg::KEY_W-1:0]      key,
	input  logic                           object_present,
	input  logic                           charge_on,
	input  logic [kla_pkg::CNT_W-1:0]      alarm_reload,
	output kla_pkg::state_t                nxt,
	output kla_pkg::result_t               res
);

	logic [kla_pkg::KEY_W-1:0] key_m;
	logic [kla_pkg::KEY_W-1:0] key_cmp;
	logic [kla_pkg::CNT_W-1:0] dec;
	logic                      dec_warn;
	logic                      rld_warn;

	assign key_m    = key & kla_pkg::KEY_MASK;
	// an unlock request presents the stored key
	assign key_cmp  = (kind == kla_pkg::KIND_UNLOCK) ? cur.stored_key : key_m;
	assign dec      = cur.count - 4'd1;
	assign dec_warn = (dec == 4'd2) || (dec == 4'd4) || (dec == 4'd8);
	// reload also warns when it happens to be a step down by one onto 8, 4 or 2
	assign rld_warn = (cur.count == (alarm_reload + 4'd1))
			&& ((alarm_reload == 4'd2) || (alarm_reload == 4'd4) || (alarm_reload == 4'd8));

	always_comb begin
		nxt             = cur;
		res.outcome     = kla_pkg::OUT_NONE;
		res.beep        = kla_pkg::BEEP_OFF;
		res.publish     = 1'b0;
		if (cur.alarm) begin
			res.outcome = kla_pkg::OUT_ALARM;
		end else begin
			case (kla_pkg::kind_t'(kind))
				kla_pkg::KIND_TICK: begin
					nxt.object_seen = object_present;
					if (cur.locked && !object_present) begin
						nxt.count = dec;
						if (dec == '0) begin
							nxt.charging = 1'b0;
							nxt.locked   = 1'b0;
							nxt.alarm    = 1'b1;
							res.outcome  = kla_pkg::OUT_ALARM;
						end else begin
							res.outcome = kla_pkg::OUT_COUNT;
							if (dec_warn) begin
								res.beep = kla_pkg::BEEP_WARN;
							end
						end
					end else if (cur.count != alarm_reload) begin
						nxt.count = alarm_reload;
						if (rld_warn) begin
							res.beep = kla_pkg::BEEP_WARN;
						end
					end
				end
				kla_pkg::KIND_CHARGE: begin
					if (cur.locked) begin
						nxt.charging = charge_on;
					end else begin
						res.outcome = kla_pkg::OUT_IGNORED;
					end
				end
				kla_pkg::KIND_KEY, kla_pkg::KIND_UNLOCK: begin
					if (cur.locked) begin
						if (key_cmp != cur.stored_key) begin
							res.outcome = kla_pkg::OUT_MISMATCH;
							res.beep    = kla_pkg::BEEP_WARN;
						end else begin
							nxt.charging = 1'b0;
							nxt.locked   = 1'b0;
							nxt.waiting  = 1'b1;
							res.outcome  = kla_pkg::OUT_UNLOCKED;
							res.beep     = kla_pkg::BEEP_OK;
							res.publish  = 1'b1;
						end
					end else if (kind == kla_pkg::KIND_KEY && cur.waiting) begin
						if (!cur.object_seen) begin
							res.outcome = kla_pkg::OUT_NO_OBJ;
							res.beep    = kla_pkg::BEEP_WARN;
						end else begin
							nxt.stored_key = key_m;
							nxt.waiting    = 1'b0;
							nxt.locked     = 1'b1;
							nxt.charging   = 1'b1;
							res.outcome    = kla_pkg::OUT_LOCKED;
							res.beep       = kla_pkg::BEEP_OK;
							res.publish    = 1'b1;
						end
					end else begin
						res.outcome = kla_pkg::OUT_IGNORED;
					end
				end
				default: begin
					res.outcome = kla_pkg::OUT_IGNORED;
				end
			endcase
		end
		res.key_out = res.publish ? nxt.stored_key : '0;
	end

endmodule

// File: rtl/core/key_locker_alarm_controller_core.sv
`timescale 1ns / 1ps
// Key locker alarm controller.
// Input channel (in_valid / in_stall) carries one event word: kind, key,
// object_present, charge_on. Output channel (out_valid / out_stall) carries
// one result word per event: outcome, beep, the state flags after the event,
// publish, key_out and count_out.
// A word is taken at a rising edge with valid high and stall low.
// An accepted event is held in the input register; its result is written
// into the output register when that is empty or not stalled. Throughput
// is one event per cycle while out_stall is low; the state update is a
// single compare-and-select pass between the input and output registers.
// When out_stall holds the output register full, the input register keeps
// its word and in_stall rises, so one further word is buffered at most.
// The APB port holds alarm_reload at address 0; write it only while idle.
// Reset: unlocked and waiting, charge off, alarm clear, stored key zero,
// countdown 10, alarm_reload 10, both channels empty.
module key_locker_alarm_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kla_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [kla_pkg::KEY_W-1:0]         key,
	input  logic                              object_present,
	input  logic                              charge_on,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        outcome,
	output logic [1:0]                        beep,
	output logic                              is_locked,
	output logic                              is_waiting,
	output logic                              is_charging,
	output logic                              alarm_on,
	output logic                              publish,
	output logic [kla_pkg::KEY_W-1:0]         key_out,
	output logic [kla_pkg::CNT_W-1:0]         count_out
);

	logic [kla_pkg::CNT_W-1:0] alarm_reload;

	logic                      valid_s1;
	logic [1:0]                kind_s1;
	logic [kla_pkg::KEY_W-1:0] key_s1;
	logic                      present_s1;
	logic                      charge_s1;

	logic                      valid_s2;
	kla_pkg::result_t          res_s2;
	kla_pkg::state_t           flags_s2;

	kla_pkg::state_t           state_q;
	kla_pkg::state_t           nxt;
	kla_pkg::result_t          res;

	logic                      load;
	logic                      advance;

	kla_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.alarm_reload (alarm_reload)
	);

	kla_step u_step (
		.cur            (state_q),
		.kind           (kind_s1),
		.key            (key_s1),
		.object_present (present_s1),
		.charge_on      (charge_s1),
		.alarm_reload   (alarm_reload),
		.nxt            (nxt),
		.res            (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1    <= kind;
			key_s1     <= key;
			present_s1 <= object_present;
			charge_s1  <= charge_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.locked      <= 1'b0;
			state_q.waiting     <= 1'b1;
			state_q.charging    <= 1'b0;
			state_q.alarm       <= 1'b0;
			state_q.stored_key  <= '0;
			state_q.count       <= kla_pkg::RELOAD_RST;
			state_q.object_seen <= 1'b0;
		end else if (advance) begin
			state_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2   <= res;
			flags_s2 <= nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign outcome     = res_s2.outcome;
	assign beep        = res_s2.beep;
	assign publish     = res_s2.publish;
	assign key_out     = res_s2.key_out;
	assign is_locked   = flags_s2.locked;
	assign is_waiting  = flags_s2.waiting;
	assign is_charging = flags_s2.charging;
	assign alarm_on    = flags_s2.alarm;
	assign count_out   = flags_s2.count;

	// once latched, the alarm holds until reset
	a_alarm_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.alarm |=> state_q.alarm)
		else $error("alarm latch released");

	a_lock_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.locked && state_q.waiting))
		else $error("locked and waiting at once");

	a_alarm_safe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.alarm |-> (!state_q.locked && !state_q.charging))
		else $error("alarm with lock or charge on");

	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.publish) |->
			(res_s2.outcome == kla_pkg::OUT_LOCKED || res_s2.outcome == kla_pkg::OUT_UNLOCKED))
		else $error("publish on an event that neither locks nor unlocks");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result word overwritten");

endmodule
